// ===== sv/hws_pkg.sv =====
package hws_pkg;

    // field widths
    localparam int IDX_W    = 10;
    localparam int SLOT_W_F = 4;
    localparam int ORDER_W  = 6;
    localparam int AMP_W    = 16;
    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 16;

    // angle table
    localparam int TABLE_SIZE = 1024;
    localparam int TBL_W      = $clog2(TABLE_SIZE);
    localparam int FRAC_SHIFT = PHASE_W - TBL_W;

    // slot table default size
    localparam int HARMONIC_SLOTS_DEF = 16;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // sine pipeline
    localparam int SINE_LAT = 7;
    localparam int Q30_FRAC = 30;
    localparam int SIN_W    = 31;
    localparam logic [SIN_W-1:0] SIN_C1  = 31'd1686629714;
    localparam logic [SIN_W-1:0] SIN_C3  = 31'd693598668;
    localparam logic [SIN_W-1:0] SIN_C5  = 31'd85569306;
    localparam logic [SIN_W-1:0] SIN_C7  = 31'd5026996;
    localparam logic [SIN_W-1:0] SIN_C9  = 31'd172272;
    localparam logic [SIN_W-1:0] SIN_ONE = 31'h4000_0000;

    // signed amplitude times sine
    localparam int PROD_W = AMP_W + SIN_W + 1;

    // request from the front queue to the engine
    typedef struct packed {
        logic                is_sample;
        logic [SLOT_W_F-1:0] slot;
        logic [ORDER_W-1:0]  order;
        logic [AMP_W-1:0]    amplitude;
        logic [PHASE_W-1:0]  phase;
        logic [IDX_W-1:0]    index;
    } cmd_t;

    // per-slot sideband that travels beside the sine pipeline
    typedef struct packed {
        logic             valid;
        logic             active;
        logic             first;
        logic             last;
        logic [AMP_W-1:0] amp;
        logic [IDX_W-1:0] index;
    } lane_t;

    // product of two non-negative q30 values, truncated back to q30
    function automatic logic [SIN_W-1:0] mul_q30(input logic [SIN_W-1:0] a,
                                                 input logic [SIN_W-1:0] b);
        logic [2*SIN_W-1:0] p;
        p = (2*SIN_W)'(a) * (2*SIN_W)'(b);
        return p[Q30_FRAC +: SIN_W];
    endfunction

endpackage

// ===== sv/harmonic_waveform_synthesizer.sv =====
// Additive harmonic synthesizer. A load request (op 0) writes order, amplitude and phase
// of one harmonic slot; loads to a slot at HARMONIC_SLOTS or beyond are dropped. A sample
// request (op 1) returns the sum of amplitude * sin(order * index / 1024 turns + phase)
// over all slots, truncated toward zero and clamped to int16, with saturated set on clamp.
// Requests enter a four-deep queue and are executed strictly in order. A sample sweeps
// the slots one per cycle through a pipelined polynomial sine and amplitude multiplier,
// and the engine takes no new request until its sweep is through. Up to four finished
// samples wait in the result queue; a full result queue holds back the next sample.
// After reset slot 0 holds the fundamental at full scale and all other slots are silent.
module harmonic_waveform_synthesizer
    import hws_pkg::*;
#(
    parameter int HARMONIC_SLOTS = HARMONIC_SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       op,
    input  logic [SLOT_W_F-1:0]        slot,
    input  logic [ORDER_W-1:0]         order,
    input  logic [AMP_W-1:0]           amplitude,
    input  logic [PHASE_W-1:0]         phase,
    input  logic [IDX_W-1:0]           table_index,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [IDX_W-1:0]           index_out,
    output logic                       saturated
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // request queue and classification
    hws_front #(
        .HARMONIC_SLOTS (HARMONIC_SLOTS)
    ) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .slot        (slot),
        .order       (order),
        .amplitude   (amplitude),
        .phase       (phase),
        .table_index (table_index),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // slot table, synthesis engine and result queue
    hws_back #(
        .HARMONIC_SLOTS (HARMONIC_SLOTS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .sample    (sample),
        .index_out (index_out),
        .saturated (saturated)
    );

    // a clamped result sits at one of the int16 limits
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && saturated) |-> (sample == 16'sh7fff || sample == -16'sh8000))
        else $error("saturated result not at a limit");

    // a waiting result is fully defined
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown({sample, index_out, saturated}))
        else $error("waiting result has unknown bits");

    // a waiting result stays put until it is taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample) && $stable(index_out)
            && $stable(saturated)))
        else $error("waiting result changed before pop");

endmodule

// ===== sv/hws_front.sv =====
module hws_front
    import hws_pkg::*;
#(
    parameter int HARMONIC_SLOTS = HARMONIC_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                op,
    input  logic [SLOT_W_F-1:0] slot,
    input  logic [ORDER_W-1:0]  order,
    input  logic [AMP_W-1:0]    amplitude,
    input  logic [PHASE_W-1:0]  phase,
    input  logic [IDX_W-1:0]    table_index,
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_pop
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             fifo_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             keep;
    logic             wr_en;
    cmd_t             in_cmd;

    // classify: loads to slots beyond the table are dropped here
    assign keep  = op || (32'(slot) < 32'(HARMONIC_SLOTS));
    assign full  = (count_reg == CNT_W'(CMD_DEPTH));
    assign wr_en = push && !full && keep;

    always_comb
    begin
        in_cmd.is_sample = op;
        in_cmd.slot      = slot;
        in_cmd.order     = order;
        in_cmd.amplitude = amplitude;
        in_cmd.phase     = phase;
        in_cmd.index     = table_index;
    end

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_en ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(wr_en) - CNT_W'(cmd_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

endmodule

// ===== sv/hws_sine.sv =====
module hws_sine
    import hws_pkg::*;
(
    input  logic               clk,
    input  logic [PHASE_W-1:0] angle,
    output logic [SIN_W-1:0]   mag,
    output logic               neg
);

    logic [14:0]      a_t_reg, b_t_reg, c_t_reg, d_t_reg, e_t_reg, f_t_reg;
    logic             a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg, e_neg_reg;
    logic             f_neg_reg, g_neg_reg;
    logic [SIN_W-1:0] b_u_reg, c_u_reg, d_u_reg, e_u_reg;
    logic [SIN_W-1:0] c_p_reg, d_p_reg, e_p_reg, f_p_reg;
    logic [SIN_W-1:0] g_mag_reg;

    logic [14:0]      pos;
    logic [14:0]      t_next;
    logic [29:0]      sq;
    logic [45:0]      tp;
    logic [31:0]      s_full;
    logic [SIN_W-1:0] s_next;

    // quadrant fold, square of the position, final product and clamp
    always_comb
    begin
        pos    = {1'b0, angle[13:0]};
        t_next = angle[14] ? 15'(15'd16384 - pos) : pos;
        sq     = 30'(a_t_reg) * 30'(a_t_reg);
        tp     = 46'(f_t_reg) * 46'(f_p_reg);
        s_full = tp[45:14];
        s_next = (s_full > 32'(SIN_ONE)) ? SIN_ONE : s_full[SIN_W-1:0];
    end

    // seven stages: fold, square, four horner steps, final multiply
    always_ff @(posedge clk)
    begin
        a_t_reg   <= t_next;
        a_neg_reg <= angle[15];

        b_t_reg   <= a_t_reg;
        b_u_reg   <= {sq[28:0], 2'b00};
        b_neg_reg <= a_neg_reg;

        c_t_reg   <= b_t_reg;
        c_u_reg   <= b_u_reg;
        c_p_reg   <= SIN_C7 - mul_q30(b_u_reg, SIN_C9);
        c_neg_reg <= b_neg_reg;

        d_t_reg   <= c_t_reg;
        d_u_reg   <= c_u_reg;
        d_p_reg   <= SIN_C5 - mul_q30(c_u_reg, c_p_reg);
        d_neg_reg <= c_neg_reg;

        e_t_reg   <= d_t_reg;
        e_u_reg   <= d_u_reg;
        e_p_reg   <= SIN_C3 - mul_q30(d_u_reg, d_p_reg);
        e_neg_reg <= d_neg_reg;

        f_t_reg   <= e_t_reg;
        f_p_reg   <= SIN_C1 - mul_q30(e_u_reg, e_p_reg);
        f_neg_reg <= e_neg_reg;

        g_mag_reg <= s_next;
        g_neg_reg <= f_neg_reg;
    end

    assign mag = g_mag_reg;
    assign neg = g_neg_reg;

endmodule

// ===== sv/hws_back.sv =====
module hws_back
    import hws_pkg::*;
#(
    parameter int HARMONIC_SLOTS = HARMONIC_SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  cmd_t                       cmd,
    output logic                       cmd_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [IDX_W-1:0]           index_out,
    output logic                       saturated
);

    localparam int SLOT_W = (HARMONIC_SLOTS > 1) ? $clog2(HARMONIC_SLOTS) : 1;
    localparam int ACC_W  = PROD_W + $clog2(HARMONIC_SLOTS) + 1;
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int MUL_W  = ORDER_W + IDX_W;
    localparam int MAG_W  = AMP_W + SIN_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HARMONIC_SLOTS - 1);
    localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(64'd32767 << Q30_FRAC);
    localparam logic signed [ACC_W-1:0] NEG_LIM = -ACC_W'(64'd32768 << Q30_FRAC);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << Q30_FRAC) - 64'd1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // slot table
    logic [ORDER_W-1:0] order_reg [HARMONIC_SLOTS];
    logic [AMP_W-1:0]   amp_reg   [HARMONIC_SLOTS];
    logic [PHASE_W-1:0] phase_reg [HARMONIC_SLOTS];

    // sequencer
    logic              state_reg, state_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] sel;
    logic [IDX_W-1:0]  cur_idx;
    logic              tbl_we;
    logic              start;
    logic              iss_fire;
    logic [SLOT_W-1:0] wr_addr;

    // issue stage
    logic [MUL_W-1:0]   rp;
    logic [TBL_W-1:0]   r;
    logic [PHASE_W-1:0] angle_next;
    lane_t              lane_next;
    logic [PHASE_W-1:0] iss_angle_reg;
    lane_t              iss_lane_reg;

    // sine and its sideband
    logic [SIN_W-1:0] sin_mag;
    logic             sin_neg;
    lane_t            lane_pipe_reg [SINE_LAT];
    lane_t            lane_s;

    // product, accumulate, result
    logic [MAG_W-1:0]         mag_prod;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic                     prod_last_reg;
    logic [IDX_W-1:0]         prod_index_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum;
    logic                     fin_valid_reg;
    logic signed [ACC_W-1:0]  fin_acc_reg;
    logic [IDX_W-1:0]         fin_index_reg;
    logic signed [ACC_W-1:0]  quot;
    logic [SAMPLE_W-1:0]      res_sample;
    logic                     res_sat;

    // result queue and credits
    logic [SAMPLE_W-1:0] out_sample_reg [OUT_DEPTH];
    logic [IDX_W-1:0]    out_index_reg  [OUT_DEPTH];
    logic                out_sat_reg    [OUT_DEPTH];
    logic [OPTR_W-1:0]   owr_ptr_reg, ord_ptr_reg;
    logic [OCNT_W-1:0]   ocount_reg;
    logic [OCNT_W-1:0]   outstanding_reg;
    logic                pop_fire;

    assign pop_fire = pop && !empty;
    assign wr_addr  = SLOT_W'(cmd.slot);

    // sequencer: loads update the table, samples sweep every slot
    always_comb
    begin
        cmd_pop    = 1'b0;
        tbl_we     = 1'b0;
        start      = 1'b0;
        iss_fire   = 1'b0;
        sel        = k_reg;
        cur_idx    = idx_reg;
        state_next = state_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_sample)
                    begin
                        tbl_we  = 1'b1;
                        cmd_pop = 1'b1;
                    end
                    else if (outstanding_reg < OCNT_W'(OUT_DEPTH))
                    begin
                        cmd_pop  = 1'b1;
                        start    = 1'b1;
                        iss_fire = 1'b1;
                        sel      = '0;
                        cur_idx  = cmd.index;
                        idx_next = cmd.index;
                        if (HARMONIC_SLOTS > 1)
                        begin
                            state_next = ST_RUN;
                            k_next     = SLOT_W'(1);
                        end
                    end
                end
            end
            ST_RUN:
            begin
                iss_fire = 1'b1;
                if (k_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                    k_next     = '0;
                end
                else
                begin
                    k_next = SLOT_W'(k_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
        end
    end

    // slot table, fundamental at full scale after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HARMONIC_SLOTS; i++)
            begin
                order_reg[i] <= (i == 0) ? ORDER_W'(1) : '0;
                amp_reg[i]   <= (i == 0) ? AMP_W'(32767) : '0;
                phase_reg[i] <= '0;
            end
        end
        else if (tbl_we)
        begin
            order_reg[wr_addr] <= cmd.order;
            amp_reg[wr_addr]   <= cmd.amplitude;
            phase_reg[wr_addr] <= cmd.phase;
        end
    end

    // issue: angle of the selected slot at the current index
    always_comb
    begin
        rp               = MUL_W'(order_reg[sel]) * MUL_W'(cur_idx);
        r                = rp[TBL_W-1:0];
        angle_next       = PHASE_W'((PHASE_W'(r) << FRAC_SHIFT) + phase_reg[sel]);
        lane_next.valid  = iss_fire;
        lane_next.active = (order_reg[sel] != '0);
        lane_next.first  = (sel == '0);
        lane_next.last   = (sel == LAST_SLOT);
        lane_next.amp    = amp_reg[sel];
        lane_next.index  = cur_idx;
    end

    always_ff @(posedge clk)
    begin
        iss_angle_reg <= angle_next;
    end

    // sideband follows the sine pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_lane_reg <= '0;
            for (int i = 0; i < SINE_LAT; i++)
            begin
                lane_pipe_reg[i] <= '0;
            end
        end
        else
        begin
            iss_lane_reg     <= lane_next;
            lane_pipe_reg[0] <= iss_lane_reg;
            for (int i = 1; i < SINE_LAT; i++)
            begin
                lane_pipe_reg[i] <= lane_pipe_reg[i-1];
            end
        end
    end

    hws_sine u_sine
    (
        .clk   (clk),
        .angle (iss_angle_reg),
        .mag   (sin_mag),
        .neg   (sin_neg)
    );

    assign lane_s = lane_pipe_reg[SINE_LAT-1];

    // amplitude times sine, zero for a disabled slot
    always_comb
    begin
        mag_prod = MAG_W'(lane_s.amp) * MAG_W'(sin_mag);
        if (!lane_s.active)
        begin
            prod_next = '0;
        end
        else if (sin_neg)
        begin
            prod_next = -$signed({1'b0, mag_prod});
        end
        else
        begin
            prod_next = $signed({1'b0, mag_prod});
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        prod_first_reg <= lane_s.first;
        prod_last_reg  <= lane_s.last;
        prod_index_reg <= lane_s.index;
    end

    // accumulate, the first slot restarts the sum
    assign sum = prod_first_reg ? ACC_W'(prod_reg) : ACC_W'(acc_reg + ACC_W'(prod_reg));

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            acc_reg <= sum;
        end
        fin_acc_reg   <= sum;
        fin_index_reg <= prod_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= lane_s.valid;
            fin_valid_reg  <= prod_valid_reg && prod_last_reg;
        end
    end

    // truncate toward zero and clamp to int16
    always_comb
    begin
        quot = (fin_acc_reg + (fin_acc_reg[ACC_W-1] ? TRUNC_BIAS : '0)) >>> Q30_FRAC;
        if (fin_acc_reg > POS_LIM)
        begin
            res_sample = 16'h7fff;
            res_sat    = 1'b1;
        end
        else if (fin_acc_reg < NEG_LIM)
        begin
            res_sample = 16'h8000;
            res_sat    = 1'b1;
        end
        else
        begin
            res_sample = quot[SAMPLE_W-1:0];
            res_sat    = 1'b0;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (fin_valid_reg)
        begin
            out_sample_reg[owr_ptr_reg] <= res_sample;
            out_index_reg[owr_ptr_reg]  <= fin_index_reg;
            out_sat_reg[owr_ptr_reg]    <= res_sat;
        end
    end

    // result queue pointers and sample credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg     <= '0;
            ord_ptr_reg     <= '0;
            ocount_reg      <= '0;
            outstanding_reg <= '0;
        end
        else
        begin
            if (fin_valid_reg)
            begin
                owr_ptr_reg <= OPTR_W'(owr_ptr_reg + 1'b1);
            end
            if (pop_fire)
            begin
                ord_ptr_reg <= OPTR_W'(ord_ptr_reg + 1'b1);
            end
            ocount_reg <= OCNT_W'(ocount_reg + OCNT_W'(fin_valid_reg) - OCNT_W'(pop_fire));
            outstanding_reg <= OCNT_W'(outstanding_reg + OCNT_W'(start) - OCNT_W'(pop_fire));
        end
    end

    assign empty     = (ocount_reg == '0);
    assign sample    = $signed(out_sample_reg[ord_ptr_reg]);
    assign index_out = out_index_reg[ord_ptr_reg];
    assign saturated = out_sat_reg[ord_ptr_reg];

endmodule
